@@ sv/crcw_pkg.sv @@
// package for the crc32 word stream block: widths, polynomial and byte table
`timescale 1ns / 1ps
package crcw_pkg;

   localparam int WORD_BYTES  = 8;
   localparam int DATA_W      = 8 * WORD_BYTES;
   localparam int CRC_W       = 32;
   localparam int COUNT_W     = 4;
   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;

   // entry of the reflected byte table: eight lsb-first shifts of an 8-bit index
   function automatic logic [CRC_W-1:0] crc_byte_table(input logic [7:0] idx);
      logic [CRC_W-1:0] r;
      r = {24'd0, idx};
      for (int b = 0; b < 8; b++) begin
         if (r[0]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

endpackage

@@ sv/crcw_req_if.sv @@
// request channel interface: message word and framing fields
`timescale 1ns / 1ps
interface crcw_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_word;
   logic        first_word;
   logic [31:0] start_value;
   logic        last_word;
   logic [3:0]  valid_bytes;

   modport source (output valid, data_word, first_word, start_value, last_word,
                   valid_bytes, input ready);
   modport sink (input valid, data_word, first_word, start_value, last_word,
                 valid_bytes, output ready);
endinterface

@@ sv/crcw_rsp_if.sv @@
// response channel interface: finished crc value
`timescale 1ns / 1ps
interface crcw_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] crc_value;

   modport source (output valid, crc_value, input ready);
   modport sink (input valid, crc_value, output ready);
endinterface

@@ sv/crcw_fold.sv @@
// folds up to eight bytes of one word into the crc, one byte lane after another
`timescale 1ns / 1ps
module crcw_fold (
   input  logic [crcw_pkg::CRC_W-1:0]   crc_in,
   input  logic [crcw_pkg::DATA_W-1:0]  data_word,
   input  logic [crcw_pkg::COUNT_W-1:0] valid_bytes,
   output logic [crcw_pkg::CRC_W-1:0]   crc_out
);
   import crcw_pkg::*;

   logic [COUNT_W-1:0] count;

   // counts above a full word fold the whole word
   assign count = (valid_bytes > COUNT_W'(WORD_BYTES)) ? COUNT_W'(WORD_BYTES) : valid_bytes;

   always_comb begin
      logic [CRC_W-1:0] r;
      logic [7:0]       lane_byte;
      r = crc_in;
      for (int k = 0; k < WORD_BYTES; k++) begin
         lane_byte = data_word[8*k +: 8];
         if (COUNT_W'(k) < count) begin
            r = (r >> 8) ^ crc_byte_table(r[7:0] ^ lane_byte);
         end
      end
      crc_out = r;
   end

endmodule

@@ sv/crc32_word_stream.sv @@
// top level: reflected crc-32 over a stream of 64-bit message words
//
//   channel  dir  handshake     payload
//   req_ch   in   valid/ready   data_word[63:0] first_word start_value[31:0]
//                               last_word valid_bytes[3:0]
//   rsp_ch   out  valid/ready   crc_value[31:0]
//
// one request per cycle while no held last word waits on a stalled response; a request
// waits in the input register, and its bytes are folded into the crc register as it advances
// a request reaches the response through the input register and then the result register
// the crc register feeds back combinationally through the eight-lane fold
// reset (synchronous, active high) clears the crc register and both valid flags
// a stalled response holds only requests that carry last_word; others keep flowing
`timescale 1ns / 1ps
module crc32_word_stream (
   input logic clock,
   input logic reset,
   crcw_req_if.sink   req_ch,
   crcw_rsp_if.source rsp_ch
);
   import crcw_pkg::*;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [DATA_W-1:0]  in_data_ff;
   logic               in_first_ff;
   logic [CRC_W-1:0]   in_start_ff;
   logic               in_last_ff;
   logic [COUNT_W-1:0] in_count_ff;

   // running crc and result register
   logic [CRC_W-1:0]   crc_ff, crc_in;
   logic               out_valid_ff, out_valid_in;
   logic [CRC_W-1:0]   out_crc_ff;

   logic               advance;
   logic               take_req;
   logic [CRC_W-1:0]   crc_base;
   logic [CRC_W-1:0]   crc_next;

   // a held word moves on unless it ends a message and the result slot is stuck
   assign advance  = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign take_req = req_ch.valid && req_ch.ready;

   // first word restarts from its start value
   assign crc_base = in_first_ff ? in_start_ff : crc_ff;

   crcw_fold u_fold (
      .crc_in      (crc_base),
      .data_word   (in_data_ff),
      .valid_bytes (in_count_ff),
      .crc_out     (crc_next)
   );

   assign in_valid_in  = take_req || (in_valid_ff && !advance);
   assign crc_in       = advance ? crc_next : crc_ff;
   assign out_valid_in = (advance && in_last_ff) || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         crc_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         crc_ff       <= crc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_data_ff  <= req_ch.data_word;
         in_first_ff <= req_ch.first_word;
         in_start_ff <= req_ch.start_value;
         in_last_ff  <= req_ch.last_word;
         in_count_ff <= req_ch.valid_bytes;
      end
      if (advance && in_last_ff) begin
         out_crc_ff <= crc_next;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.crc_value = out_crc_ff;

   // an empty input register always takes a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ch.ready)
      else $error("request refused with empty input register");

   // a message end produces a response carrying the folded crc
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> out_valid_ff && out_crc_ff == $past(crc_next))
      else $error("last word did not load the result register");

   // every advancing word updates the running crc
   a_crc_update: assert property (@(posedge clock) disable iff (reset)
      advance |=> crc_ff == $past(crc_next))
      else $error("crc register missed an update");

   // the crc holds while no word moves
   a_crc_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(crc_ff))
      else $error("crc register changed without a word");

   // reset empties both stages
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !in_valid_ff && !out_valid_ff && crc_ff == '0)
      else $error("reset left pipeline state");

endmodule

@@ bench/tb_crc32_word_stream.sv @@
// testbench for crc32_word_stream: directed table, random framed messages, bitwise crc predictor
`timescale 1ns / 1ps
module tb_crc32_word_stream;
   import crcw_pkg::*;

   // one request as the sender sees it
   typedef struct packed {
      logic [DATA_W-1:0]  data;
      logic               first;
      logic [CRC_W-1:0]   start;
      logic               last;
      logic [COUNT_W-1:0] count;
   } crc_req_type;

   // directed row: request plus an optional crc typed in by hand
   typedef struct packed {
      crc_req_type      req;
      logic             known;
      logic [CRC_W-1:0] crc;
   } crc_row_type;

   localparam int NUM_DIRECTED = 23;
   localparam int RANDOM_ITEMS = 1500;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AT      = 400;
   localparam int DRAIN_AT     = 1000;
   localparam int TAIL_CYCLES  = 10;

   localparam crc_row_type DIRECTED [NUM_DIRECTED] = '{
      // after reset, no first word, nothing folded: register is still zero
      '{'{64'h0, 1'b0, 32'h0, 1'b1, 4'd0}, 1'b1, 32'h0},
      // zero bytes into a zero register stay zero
      '{'{64'h0, 1'b1, 32'h0, 1'b1, 4'd8}, 1'b1, 32'h0},
      // top byte left out by a count of seven
      '{'{64'hFF00_0000_0000_0000, 1'b1, 32'h0, 1'b1, 4'd7}, 1'b1, 32'h0},
      // count zero on a first and last word emits the start value
      '{'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 4'd0}, 1'b1, 32'hFFFF_FFFF},
      // standard check string "123456789", start all ones, no final inversion
      '{'{64'h3837_3635_3433_3231, 1'b1, 32'hFFFF_FFFF, 1'b0, 4'd8}, 1'b0, 32'h0},
      '{'{64'h0000_0000_0000_0039, 1'b0, 32'h0, 1'b1, 4'd1}, 1'b1, 32'h340B_C6D9},
      // register keeps its value after a last word; start ignored without first
      '{'{64'hDEAD_BEEF_0000_0000, 1'b0, 32'hAAAA_AAAA, 1'b1, 4'd0}, 1'b1, 32'h340B_C6D9},
      // first word with count zero only loads the register
      '{'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h1234_5678, 1'b0, 4'd0}, 1'b0, 32'h0},
      '{'{64'h0, 1'b0, 32'h0, 1'b1, 4'd0}, 1'b1, 32'h1234_5678},
      '{'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 4'd8}, 1'b0, 32'h0},
      // counts above the word size fold in all eight bytes
      '{'{64'h0123_4567_89AB_CDEF, 1'b1, 32'h5555_5555, 1'b1, 4'd9}, 1'b0, 32'h0},
      '{'{64'hFEDC_BA98_7654_3210, 1'b1, 32'hAAAA_AAAA, 1'b1, 4'd15}, 1'b0, 32'h0},
      // every short count on a single-word message
      '{'{64'h1122_3344_5566_7788, 1'b1, 32'h0000_0001, 1'b1, 4'd1}, 1'b0, 32'h0},
      '{'{64'h99AA_BBCC_DDEE_FF00, 1'b1, 32'h8000_0000, 1'b1, 4'd2}, 1'b0, 32'h0},
      '{'{64'hCAFE_F00D_1234_ABCD, 1'b1, 32'hFFFF_FFFE, 1'b1, 4'd3}, 1'b0, 32'h0},
      '{'{64'h0F1E_2D3C_4B5A_6978, 1'b1, 32'h7FFF_FFFF, 1'b1, 4'd4}, 1'b0, 32'h0},
      '{'{64'h8796_A5B4_C3D2_E1F0, 1'b1, 32'hC001_D00D, 1'b1, 4'd5}, 1'b0, 32'h0},
      '{'{64'h5A5A_5A5A_A5A5_A5A5, 1'b1, 32'h0000_FFFF, 1'b1, 4'd6}, 1'b0, 32'h0},
      '{'{64'h0000_0000_0000_00FF, 1'b1, 32'hFFFF_0000, 1'b1, 4'd7}, 1'b0, 32'h0},
      // short count on a word that is not the last, then long counts, then a new one-word message
      '{'{64'hA5A5_5A5A_C3C3_3C3C, 1'b1, 32'h0F0F_F0F0, 1'b0, 4'd3}, 1'b0, 32'h0},
      '{'{64'h8000_0000_0000_0001, 1'b0, 32'h0, 1'b0, 4'd12}, 1'b0, 32'h0},
      '{'{64'h7FFF_FFFF_FFFF_FFFE, 1'b0, 32'hFFFF_FFFF, 1'b1, 4'd8}, 1'b0, 32'h0},
      '{'{64'h0000_0000_0000_0001, 1'b1, 32'h8000_0001, 1'b1, 4'd1}, 1'b0, 32'h0}
   };

   logic clock;
   logic reset;

   crcw_req_if req_ch ();
   crcw_rsp_if rsp_ch ();

   crc32_word_stream u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // running crc as the predictor sees it, and crc values still owed by the block
   logic [CRC_W-1:0] crc_running;
   logic [CRC_W-1:0] crc_expected_q [$];
   logic [CRC_W-1:0] crc_oldest;
   int               mismatch_count;
   int               requests_sent;
   bit               hold_rsp_req;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: end the run with an error if it has not finished
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // fold count bytes of a word into the crc, lsb first, counts above the word size clamp
   function automatic logic [CRC_W-1:0] crc_fold_word(input logic [CRC_W-1:0] crc_in,
                                                      input logic [DATA_W-1:0] word,
                                                      input logic [COUNT_W-1:0] count);
      logic [CRC_W-1:0] crc;
      int               nbytes;
      crc    = crc_in;
      nbytes = (count > WORD_BYTES) ? WORD_BYTES : int'(count);
      for (int k = 0; k < nbytes; k++) begin
         crc = crc ^ {24'd0, word[8*k +: 8]};
         for (int b = 0; b < 8; b++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
         end
      end
      return crc;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic note_mismatch(input logic [CRC_W-1:0] want, input logic [CRC_W-1:0] got,
                                input bit orphan);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         if (orphan) begin
            $display("crc response with no request pending: crc_value %08h", got);
         end else begin
            $display("crc mismatch: crc_value expected %08h got %08h", want, got);
         end
      end
   endtask

   // offer one request, wait for the handshake, predict, then drop valid and idle if gap is nonzero
   // called right after a rising edge; leaves time at a rising edge
   task automatic send_request(input crc_req_type r, input bit known,
                               input logic [CRC_W-1:0] crc, input int gap);
      req_ch.data_word   <= r.data;
      req_ch.first_word  <= r.first;
      req_ch.start_value <= r.start;
      req_ch.last_word   <= r.last;
      req_ch.valid_bytes <= r.count;
      req_ch.valid       <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;
      // accepted: advance the running crc exactly as the block should
      crc_running = crc_fold_word(r.first ? r.start : crc_running, r.data, r.count);
      if (r.last) begin
         crc_expected_q.push_back(known ? crc : crc_running);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // well-formed message: optional first word, full middle words, last word of one to eight bytes
   task automatic send_message(input int nwords, input bit with_first, input bit no_gaps);
      crc_req_type r;
      for (int w = 0; w < nwords; w++) begin
         r.data  = {$urandom, $urandom};
         r.first = with_first && (w == 0);
         r.start = $urandom;
         r.last  = (w == nwords - 1);
         r.count = r.last ? 4'($urandom_range(1, WORD_BYTES)) : 4'(WORD_BYTES);
         send_request(r, 1'b0, '0, no_gaps ? 0 : pick_gap());
      end
   endtask

   // stop offering and wait until every owed crc has come back
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (crc_expected_q.size() != 0);
   endtask

   // response checker: compare each accepted crc with the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (crc_expected_q.size() == 0) begin
            note_mismatch('0, rsp_ch.crc_value, 1'b1);
         end else begin
            crc_oldest = crc_expected_q.pop_front();
            if (rsp_ch.crc_value !== crc_oldest) begin
               note_mismatch(crc_oldest, rsp_ch.crc_value, 1'b0);
            end
         end
      end
   end

   // response side: random ready stretches, plus one long hold-off on request
   initial begin
      int run_len;
      int gap;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp_req) begin
            // long stall so the block fills and pushes back on the sender
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp_req = 1'b0;
         end else begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 8);
            rsp_ch.ready <= 1'b1;
            repeat (run_len) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // request side: reset, directed table, random messages, drain, verdict
   initial begin
      crc_req_type r;
      int          pick;
      int          nwords;
      bit          hold_done;
      bit          drain_done;
      crc_running        = '0;
      mismatch_count     = 0;
      requests_sent      = 0;
      hold_rsp_req       = 1'b0;
      hold_done          = 1'b0;
      drain_done         = 1'b0;
      req_ch.valid       <= 1'b0;
      req_ch.data_word   <= '0;
      req_ch.first_word  <= 1'b0;
      req_ch.start_value <= '0;
      req_ch.last_word   <= 1'b0;
      req_ch.valid_bytes <= '0;
      reset              <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table: hand-typed crc where obvious, predictor elsewhere
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_request(DIRECTED[i].req, DIRECTED[i].known, DIRECTED[i].crc, pick_gap());
      end

      // random part: mostly framed messages with random payload, some noise
      while (requests_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
         if (!hold_done && requests_sent >= HOLD_AT) begin
            // keep offering single-word messages while the response side is held off
            hold_rsp_req = 1'b1;
            while (hold_rsp_req) send_message(1, 1'b1, 1'b1);
            hold_done = 1'b1;
         end else if (!drain_done && requests_sent >= DRAIN_AT) begin
            drain_responses();
            drain_done = 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               // noise: any framing bits and any count, zero and oversized included
               r.data  = {$urandom, $urandom};
               r.first = 1'($urandom_range(0, 1));
               r.start = $urandom;
               r.last  = 1'($urandom_range(0, 1));
               r.count = 4'($urandom_range(0, 15));
               send_request(r, 1'b0, '0, pick_gap());
            end else begin
               pick   = $urandom_range(0, 99);
               nwords = (pick < 70) ? $urandom_range(1, 4) :
                        (pick < 95) ? $urandom_range(5, 12) : $urandom_range(13, 40);
               // a few messages continue from the current register without a first word
               send_message(nwords, $urandom_range(0, 19) != 0,
                            $urandom_range(0, 7) == 0);
            end
         end
      end

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && crc_expected_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
